// ===== rtl/core/rsst_pkg.sv =====
// Shared types and constants of the range-sum segment tree core.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package rsst_pkg;

  // Field widths of the request and response items.
  localparam int IDX_IN_W = 10;
  localparam int VALUE_W  = 16;
  localparam int TOTAL_W  = 26;
  localparam int LEN_W    = 11;
  localparam int ERR_W    = 2;

  // Length register value after reset.
  localparam logic [LEN_W-1:0] RESET_LENGTH = 11'd1024;

  // Command codes.
  localparam logic CMD_SET = 1'b0;
  localparam logic CMD_SUM = 1'b1;

  // Error codes.
  localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_RANGE = 2'd1;
  localparam logic [ERR_W-1:0] ERR_ORDER = 2'd2;

  // Decision of one tree walk step. Exactly one member is set.
  typedef struct packed {
    logic exact;       // range equals the node's span
    logic go_left;     // range lies in the left child
    logic go_right;    // range lies in the right child
    logic take_left;   // left child fully covered, walk on to the right
    logic take_right;  // right child fully covered, walk on to the left
    logic split;       // range straddles mid and touches neither end
  } step_t;

endpackage

`default_nettype wire

// ===== rtl/core/rsst_interfaces.sv =====
// Valid/ready channel interfaces for requests, responses and the length register.
// Depends on rsst_pkg for the field widths.
`default_nettype none

interface rsst_req_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 command;
  logic [rsst_pkg::IDX_IN_W-1:0]        first_index;
  logic [rsst_pkg::IDX_IN_W-1:0]        last_index;
  logic signed [rsst_pkg::VALUE_W-1:0]  new_value;

  modport source (output valid, command, first_index, last_index, new_value, input ready);
  modport sink   (input valid, command, first_index, last_index, new_value, output ready);
endinterface

interface rsst_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [rsst_pkg::TOTAL_W-1:0]  range_total;
  logic [rsst_pkg::ERR_W-1:0]           error_code;

  modport source (output valid, range_total, error_code, input ready);
  modport sink   (input valid, range_total, error_code, output ready);
endinterface

interface rsst_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [rsst_pkg::LEN_W-1:0]   data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/range_sum_segment_tree_core.sv =====
// Range-sum segment tree core: top level with the node memory and the walk sequencer.
// Depends on rsst_pkg, the channel interfaces and rsst_step.
//
// The core keeps a segment tree of 26-bit partial sums in one synchronous memory
// of 2*2^ceil(log2(MAX_ELEMENTS)) entries in heap order (2048 for the default).
// After reset it writes zeros to every entry and takes no request item until that
// pass ends; writes of the length register are taken at any time. A set walks from
// the root to the leaf at one level per cycle, writes the leaf, then climbs back at
// one level per cycle, reading the sibling and writing the parent sum. A query walks
// the tree once, reading at most one fully covered node per cycle; it splits into a
// left and a right walk at most once. The single registered memory read port sets
// this pace. The next request item can be taken in the cycle after the output
// register is loaded. A request with an index at or beyond the length in use, or a
// reversed range, goes straight to the response state with an error code and a zero
// total, and touches nothing. Items are handled one at a time; a finished response
// sits in an output register, so the next request item is taken while the previous
// response still waits for the sink.
`default_nettype none

module range_sum_segment_tree_core #(
  parameter int unsigned MAX_ELEMENTS = 1024
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  rsst_req_if.sink    in_req,
  rsst_rsp_if.source  out_rsp,
  rsst_cfg_if.sink    cfg_wr
);

  localparam int IDX_W  = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int NODE_W = IDX_W + 1;
  localparam int DEPTH  = 2 ** NODE_W;
  localparam int TW     = rsst_pkg::TOTAL_W;
  localparam int VW     = rsst_pkg::VALUE_W;
  localparam int EW     = rsst_pkg::ERR_W;
  localparam int LW     = rsst_pkg::LEN_W;

  localparam logic [NODE_W-1:0] ROOT    = NODE_W'(1);
  localparam logic [IDX_W-1:0]  TOP_IDX = IDX_W'(MAX_ELEMENTS - 1);

  // Sequencer states.
  localparam logic [2:0] ST_CLEAR = 3'd0;  // zeroing pass after reset
  localparam logic [2:0] ST_IDLE  = 3'd1;  // waiting for a request item
  localparam logic [2:0] ST_WALK  = 3'd2;  // descending the tree
  localparam logic [2:0] ST_ASC   = 3'd3;  // set: climbing back, rewriting sums
  localparam logic [2:0] ST_DRAIN = 3'd4;  // query: fold in the last read
  localparam logic [2:0] ST_RESP  = 3'd5;  // hand the result to the output register

  // Control state.
  logic [2:0]        state_r,    state_nxt;
  logic [NODE_W-1:0] clr_cnt_r,  clr_cnt_nxt;
  logic [LW-1:0]     len_r,      len_nxt;
  logic              sv_valid_r, sv_valid_nxt;
  logic              pend_r,     pend_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Payload state.
  logic              cmd_r,      cmd_nxt;
  logic [NODE_W-1:0] node_r,     node_nxt;
  logic [IDX_W-1:0]  lo_r,       lo_nxt;
  logic [IDX_W-1:0]  hi_r,       hi_nxt;
  logic [IDX_W-1:0]  a_r,        a_nxt;
  logic [IDX_W-1:0]  b_r,        b_nxt;
  logic [NODE_W-1:0] sv_node_r,  sv_node_nxt;
  logic [IDX_W-1:0]  sv_lo_r,    sv_lo_nxt;
  logic [IDX_W-1:0]  sv_hi_r,    sv_hi_nxt;
  logic [IDX_W-1:0]  sv_b_r,     sv_b_nxt;
  logic [TW-1:0]     acc_r,      acc_nxt;
  logic [VW-1:0]     val_r,      val_nxt;
  logic [EW-1:0]     err_r,      err_nxt;
  logic [TW-1:0]     out_total_r, out_total_nxt;
  logic [EW-1:0]     out_err_r,  out_err_nxt;

  // Node memory: one write port, one registered read port.
  logic [TW-1:0]     node_mem [DEPTH];
  logic              mem_we;
  logic [NODE_W-1:0] mem_waddr;
  logic [TW-1:0]     mem_wdata;
  logic [NODE_W-1:0] mem_raddr;
  logic [TW-1:0]     rd_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      node_mem[mem_waddr] <= mem_wdata;
    end
    rd_r <= node_mem[mem_raddr];
  end

  // Split point and step decision for the node under the walk.
  logic [IDX_W-1:0] mid;
  rsst_pkg::step_t  dec;

  rsst_step #(
    .IDX_W (IDX_W)
  ) u_step (
    .lo  (lo_r),
    .hi  (hi_r),
    .a   (a_r),
    .b   (b_r),
    .mid (mid),
    .dec (dec)
  );

  // Heap neighbors of the current node.
  logic [NODE_W-1:0] child_l, child_r, parent, sibling, parent_sib;
  logic [IDX_W-1:0]  mid_p1;

  assign child_l    = {node_r[NODE_W-2:0], 1'b0};
  assign child_r    = {node_r[NODE_W-2:0], 1'b1};
  assign parent     = {1'b0, node_r[NODE_W-1:1]};
  assign sibling    = {node_r[NODE_W-1:1], ~node_r[0]};
  assign parent_sib = {1'b0, node_r[NODE_W-1:2], ~node_r[1]};
  assign mid_p1     = mid + 1'b1;

  // Index checks on the incoming item. The usable length is the register value
  // capped at the array size.
  logic first_ok, last_ok, in_fire, rsp_free;
  logic [TW-1:0] acc_sum, leaf_val;

  assign first_ok = ({1'b0, in_req.first_index} < len_r) &&
                    (32'(in_req.first_index) < MAX_ELEMENTS);
  assign last_ok  = ({1'b0, in_req.last_index} < len_r) &&
                    (32'(in_req.last_index) < MAX_ELEMENTS);
  assign in_fire  = in_req.valid && in_req.ready;
  assign rsp_free = !out_valid_r || out_rsp.ready;
  assign acc_sum  = acc_r + rd_r;
  assign leaf_val = {{(TW - VW){val_r[VW-1]}}, val_r};

  assign in_req.ready = (state_r == ST_IDLE);
  assign cfg_wr.ready = 1'b1;

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    len_nxt       = len_r;
    sv_valid_nxt  = sv_valid_r;
    pend_nxt      = 1'b0;
    out_valid_nxt = out_valid_r;
    cmd_nxt       = cmd_r;
    node_nxt      = node_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    sv_node_nxt   = sv_node_r;
    sv_lo_nxt     = sv_lo_r;
    sv_hi_nxt     = sv_hi_r;
    sv_b_nxt      = sv_b_r;
    acc_nxt       = pend_r ? acc_sum : acc_r;
    val_nxt       = val_r;
    err_nxt       = err_r;
    out_total_nxt = out_total_r;
    out_err_nxt   = out_err_r;
    mem_we        = 1'b0;
    mem_waddr     = node_r;
    mem_wdata     = leaf_val;
    mem_raddr     = node_r;

    if (cfg_wr.valid && cfg_wr.ready) begin
      len_nxt = cfg_wr.data;
    end

    if (out_valid_r && out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wdata = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == {NODE_W{1'b1}}) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_fire) begin
          cmd_nxt      = in_req.command;
          val_nxt      = in_req.new_value;
          node_nxt     = ROOT;
          lo_nxt       = '0;
          hi_nxt       = TOP_IDX;
          a_nxt        = IDX_W'(in_req.first_index);
          b_nxt        = (in_req.command == rsst_pkg::CMD_SUM) ?
                         IDX_W'(in_req.last_index) : IDX_W'(in_req.first_index);
          sv_valid_nxt = 1'b0;
          acc_nxt      = '0;
          err_nxt      = rsst_pkg::ERR_OK;
          state_nxt    = ST_WALK;
          if (in_req.command == rsst_pkg::CMD_SUM) begin
            if (!first_ok || !last_ok) begin
              err_nxt   = rsst_pkg::ERR_RANGE;
              state_nxt = ST_RESP;
            end else if (in_req.first_index > in_req.last_index) begin
              err_nxt   = rsst_pkg::ERR_ORDER;
              state_nxt = ST_RESP;
            end
          end else if (!first_ok) begin
            err_nxt   = rsst_pkg::ERR_RANGE;
            state_nxt = ST_RESP;
          end
        end
      end

      ST_WALK: begin
        if (dec.exact) begin
          if (cmd_r == rsst_pkg::CMD_SUM) begin
            // Whole node inside the range: add it, then resume any saved right walk.
            mem_raddr = node_r;
            pend_nxt  = 1'b1;
            if (sv_valid_r) begin
              sv_valid_nxt = 1'b0;
              node_nxt     = sv_node_r;
              lo_nxt       = sv_lo_r;
              hi_nxt       = sv_hi_r;
              a_nxt        = sv_lo_r;
              b_nxt        = sv_b_r;
            end else begin
              state_nxt = ST_DRAIN;
            end
          end else begin
            // Leaf reached: write it and fetch its sibling for the climb.
            mem_we    = 1'b1;
            mem_waddr = node_r;
            mem_wdata = leaf_val;
            acc_nxt   = leaf_val;
            mem_raddr = sibling;
            state_nxt = ST_ASC;
          end
        end else if (dec.go_left) begin
          node_nxt = child_l;
          hi_nxt   = mid;
        end else if (dec.go_right) begin
          node_nxt = child_r;
          lo_nxt   = mid_p1;
        end else if (dec.take_left) begin
          mem_raddr = child_l;
          pend_nxt  = 1'b1;
          node_nxt  = child_r;
          lo_nxt    = mid_p1;
          a_nxt     = mid_p1;
        end else if (dec.take_right) begin
          mem_raddr = child_r;
          pend_nxt  = 1'b1;
          node_nxt  = child_l;
          hi_nxt    = mid;
          b_nxt     = mid;
        end else begin
          // First true split of a query: park the right half, follow the left.
          sv_valid_nxt = 1'b1;
          sv_node_nxt  = child_r;
          sv_lo_nxt    = mid_p1;
          sv_hi_nxt    = hi_r;
          sv_b_nxt     = b_r;
          node_nxt     = child_l;
          hi_nxt       = mid;
          b_nxt        = mid;
        end
      end

      ST_ASC: begin
        // Sibling data is in rd_r; the parent's new sum goes straight back.
        mem_we    = 1'b1;
        mem_waddr = parent;
        mem_wdata = acc_sum;
        acc_nxt   = acc_sum;
        node_nxt  = parent;
        mem_raddr = parent_sib;
        if (parent == ROOT) begin
          state_nxt = ST_RESP;
        end
      end

      ST_DRAIN: begin
        state_nxt = ST_RESP;
      end

      ST_RESP: begin
        if (rsp_free) begin
          out_valid_nxt = 1'b1;
          out_total_nxt = (cmd_r == rsst_pkg::CMD_SUM) ? acc_r : '0;
          out_err_nxt   = err_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      len_r       <= rsst_pkg::RESET_LENGTH;
      sv_valid_r  <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      len_r       <= len_nxt;
      sv_valid_r  <= sv_valid_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    node_r      <= node_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    sv_node_r   <= sv_node_nxt;
    sv_lo_r     <= sv_lo_nxt;
    sv_hi_r     <= sv_hi_nxt;
    sv_b_r      <= sv_b_nxt;
    acc_r       <= acc_nxt;
    val_r       <= val_nxt;
    err_r       <= err_nxt;
    out_total_r <= out_total_nxt;
    out_err_r   <= out_err_nxt;
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.range_total = out_total_r;
  assign out_rsp.error_code  = out_err_r;

endmodule

`default_nettype wire

// ===== rtl/core/rsst_step.sv =====
// One step of the segment tree walk: the node's split point and where the range goes.
// Depends on rsst_pkg for the step decision type.
`default_nettype none

module rsst_step #(
  parameter int IDX_W = 10
) (
  input  wire logic [IDX_W-1:0] lo,
  input  wire logic [IDX_W-1:0] hi,
  input  wire logic [IDX_W-1:0] a,
  input  wire logic [IDX_W-1:0] b,
  output logic      [IDX_W-1:0] mid,
  output rsst_pkg::step_t       dec
);

  logic [IDX_W-1:0] span;

  always_comb begin
    span = hi - lo;
    mid  = lo + (span >> 1);
    dec  = '0;
    if (a == lo && b == hi) begin
      dec.exact = 1'b1;
    end else if (b <= mid) begin
      dec.go_left = 1'b1;
    end else if (a > mid) begin
      dec.go_right = 1'b1;
    end else if (a == lo) begin
      dec.take_left = 1'b1;
    end else if (b == hi) begin
      dec.take_right = 1'b1;
    end else begin
      dec.split = 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/rsst_checker.sv =====
// Port-level assertions for the range-sum segment tree core, bound to its top level.
// Depends on rsst_pkg for the error codes.
`default_nettype none

module rsst_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [rsst_pkg::TOTAL_W-1:0]  range_total,
  input wire logic [rsst_pkg::ERR_W-1:0]    error_code
);

  // A stalled response keeps its valid and its payload.
  a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(range_total) && $stable(error_code))
    else $error("response changed while stalled");

  // An error response always carries a zero total.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && error_code != rsst_pkg::ERR_OK |-> range_total == '0)
    else $error("error response with nonzero total");

  // The memory clearing pass keeps requests out right after reset.
  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("request taken during clearing pass");

  // Items are handled one at a time: no request is taken the cycle after another.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

endmodule

bind range_sum_segment_tree_core rsst_checker u_rsst_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_req.valid),
  .in_ready    (in_req.ready),
  .out_valid   (out_rsp.valid),
  .out_ready   (out_rsp.ready),
  .range_total (out_rsp.range_total),
  .error_code  (out_rsp.error_code)
);

`default_nettype wire
